// ===== design/tvv_pkg.sv =====
// ----------------------------------------------------------------------------
// tvv_pkg
// Shared types, codes and constants of the typed value validator.
// ----------------------------------------------------------------------------
package tvv_pkg;

    localparam int TVV_WORD_BITS = 64;

    localparam logic [2:0] VT_STRING   = 3'd0;
    localparam logic [2:0] VT_BOOLEAN  = 3'd1;
    localparam logic [2:0] VT_UNSIGNED = 3'd2;
    localparam logic [2:0] VT_SIGNED   = 3'd3;

    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_SPACE  = 2'd1;
    localparam logic [1:0] PH_SIGN   = 2'd2;
    localparam logic [1:0] PH_DIGITS = 2'd3;

    localparam logic [1:0] BF_NONE  = 2'd0;
    localparam logic [1:0] BF_TRUE  = 2'd1;
    localparam logic [1:0] BF_FALSE = 2'd2;

    localparam logic [2:0] BYTE_CNT_MAX = 3'd6;
    localparam logic [2:0] TRUE_LEN     = 3'd4;
    localparam logic [2:0] FALSE_LEN    = 3'd5;

    typedef struct packed {
        logic [2:0] vtype;
        logic [1:0] phase;
        logic       overflowed;
        logic       is_negative;
        logic       saw_digit;
        logic       saw_minus;
        logic       match_true;
        logic       match_false;
        logic [2:0] byte_count;
        logic       already_bad;
    } t_scan_ctl;

    localparam t_scan_ctl SCAN_CLEAR = '{
        vtype:       VT_STRING,
        phase:       PH_START,
        overflowed:  1'b0,
        is_negative: 1'b0,
        saw_digit:   1'b0,
        saw_minus:   1'b0,
        match_true:  1'b1,
        match_false: 1'b1,
        byte_count:  3'd0,
        already_bad: 1'b0
    };

    typedef struct packed {
        logic       done;
        logic       status;
        logic [1:0] form;
    } t_verdict;

    function automatic logic [7:0] true_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h74;
            3'd1:    c = 8'h72;
            3'd2:    c = 8'h75;
            3'd3:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] false_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h66;
            3'd1:    c = 8'h61;
            3'd2:    c = 8'h6c;
            3'd3:    c = 8'h73;
            3'd4:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== design/tvv_step.sv =====
// ----------------------------------------------------------------------------
// tvv_step
// Per-transaction next-state and verdict logic of the value scanner.
// ----------------------------------------------------------------------------
module tvv_step import tvv_pkg::*; #(
    parameter int WORD_BITS = TVV_WORD_BITS
) (
    input  t_scan_ctl              i_ctl,
    input  logic [WORD_BITS-1:0]   i_mag,
    input  logic [2:0]             i_value_type,
    input  logic                   i_nil_value,
    input  logic                   i_has_byte,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last_byte,
    output t_scan_ctl              o_ctl,
    output logic [WORD_BITS-1:0]   o_mag,
    output t_verdict               o_verdict
);

    localparam int PW = WORD_BITS + 4;

    logic [2:0]           eff_type;
    logic [7:0]           low;
    logic                 is_digit;
    logic                 is_space;
    logic [WORD_BITS-1:0] lim;
    logic [PW-1:0]        mag_ext;
    logic [PW-1:0]        prod;
    logic                 over;
    logic                 take_digit;
    t_scan_ctl            s;
    logic [WORD_BITS-1:0] m;

    assign eff_type = (i_ctl.phase == PH_START) ? i_value_type : i_ctl.vtype;
    assign low      = (i_data_byte >= 8'h41 && i_data_byte <= 8'h5a)
                      ? (i_data_byte + 8'd32) : i_data_byte;
    assign is_digit = (i_data_byte >= 8'h30 && i_data_byte <= 8'h39);
    assign is_space = (i_data_byte == 8'h20)
                      || (i_data_byte >= 8'h09 && i_data_byte <= 8'h0d);

    always_comb begin
        if (eff_type == VT_UNSIGNED) begin
            lim = '1;
        end else if (i_ctl.is_negative) begin
            lim = {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            lim = {1'b0, {(WORD_BITS-1){1'b1}}};
        end
    end

    assign mag_ext = {4'd0, i_mag};
    assign prod    = (mag_ext << 3) + (mag_ext << 1) + {{(PW-4){1'b0}}, i_data_byte[3:0]};
    assign over    = prod > {4'd0, lim};

    always_comb begin
        s          = i_ctl;
        m          = i_mag;
        take_digit = 1'b0;
        o_verdict  = '{done: 1'b0, status: 1'b1, form: BF_NONE};

        if (s.phase == PH_START) begin
            s.vtype = i_value_type;
            s.phase = PH_SPACE;
        end

        if (i_has_byte) begin
            if (s.byte_count >= TRUE_LEN || low != true_char(s.byte_count)) begin
                s.match_true = 1'b0;
            end
            if (s.byte_count >= FALSE_LEN || low != false_char(s.byte_count)) begin
                s.match_false = 1'b0;
            end
            if (s.byte_count < BYTE_CNT_MAX) begin
                s.byte_count = s.byte_count + 3'd1;
            end
            if (!s.already_bad) begin
                if (s.phase == PH_SPACE) begin
                    priority if (is_space) begin
                        s.phase = PH_SPACE;
                    end else if (i_data_byte == 8'h2b) begin
                        s.phase = PH_SIGN;
                    end else if (i_data_byte == 8'h2d) begin
                        s.saw_minus   = 1'b1;
                        s.is_negative = 1'b1;
                        s.phase       = PH_SIGN;
                    end else if (is_digit) begin
                        take_digit = 1'b1;
                    end else begin
                        s.already_bad = 1'b1;
                    end
                end else if (is_digit) begin
                    take_digit = 1'b1;
                end else begin
                    s.already_bad = 1'b1;
                end
                if (take_digit) begin
                    s.saw_digit = 1'b1;
                    s.phase     = PH_DIGITS;
                    if (!s.overflowed) begin
                        if (over) begin
                            s.overflowed = 1'b1;
                        end else begin
                            m = prod[WORD_BITS-1:0];
                        end
                    end
                end
            end
        end

        if (i_last_byte) begin
            o_verdict.done = 1'b1;
            unique case (s.vtype)
                VT_STRING: begin
                    o_verdict.status = 1'b0;
                end
                VT_BOOLEAN: begin
                    if (s.match_true && s.byte_count == TRUE_LEN) begin
                        o_verdict.status = 1'b0;
                        o_verdict.form   = BF_TRUE;
                    end else if (s.match_false && s.byte_count == FALSE_LEN) begin
                        o_verdict.status = 1'b0;
                        o_verdict.form   = BF_FALSE;
                    end
                end
                VT_UNSIGNED: begin
                    if (!s.already_bad && s.saw_digit && !s.overflowed && !s.saw_minus) begin
                        o_verdict.status = 1'b0;
                    end
                end
                VT_SIGNED: begin
                    if (!s.already_bad && s.saw_digit && !s.overflowed) begin
                        o_verdict.status = 1'b0;
                    end
                end
                default: begin
                    o_verdict.status = 1'b1;
                end
            endcase
            s = SCAN_CLEAR;
            m = '0;
        end

        if (i_nil_value) begin
            if (i_last_byte) begin
                o_verdict = '{done: 1'b1, status: 1'b0, form: BF_NONE};
                s         = SCAN_CLEAR;
                m         = '0;
            end else begin
                o_verdict = '{done: 1'b0, status: 1'b1, form: BF_NONE};
                s         = i_ctl;
                m         = i_mag;
            end
        end

        o_ctl = s;
        o_mag = m;
    end

endmodule

// ===== design/typed_value_validator.sv =====
// ----------------------------------------------------------------------------
// typed_value_validator
// Checks a byte-stream value against its declared type, one verdict per value.
// ----------------------------------------------------------------------------
// channel   dir  tdata                          tuser                   tlast
// s_axis    in   [7:0] data_byte                [2:0] value_type,       last_byte
//                                               [3] nil_value,
//                                               [4] has_byte
// m_axis    out  [0] status, [2:1] boolean_form -                       -
//
// One transaction per cycle while no verdict is stalled; a byte is scanned in
// the cycle after it is taken, and a value's verdict is registered as its last byte advances.
// The per-byte multiply-by-ten, add and limit compare set the cycle path.
// Reset is synchronous, active low, and clears all scan state.
// A stalled verdict holds the next last byte in the input register, and with
// it the slave side; bytes ahead of that one keep flowing.
// ----------------------------------------------------------------------------
module typed_value_validator import tvv_pkg::*; #(
    parameter int WORD_BITS = TVV_WORD_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [4:0] s_axis_tuser,   // [2:0] value_type, [3] nil_value, [4] has_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] status, [2:1] boolean_form, [7:3] zero
);

    logic                 r_in_valid;
    logic [2:0]           r_in_type;
    logic                 r_in_nil;
    logic                 r_in_hb;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;
    t_scan_ctl            r_ctl;
    logic [WORD_BITS-1:0] r_mag;
    logic                 r_out_valid;
    logic                 r_out_status;
    logic [1:0]           r_out_form;

    t_scan_ctl            n_ctl;
    logic [WORD_BITS-1:0] n_mag;
    t_verdict             verdict;
    logic                 advance;

    tvv_step #(
        .WORD_BITS (WORD_BITS)
    ) u_step (
        .i_ctl        (r_ctl),
        .i_mag        (r_mag),
        .i_value_type (r_in_type),
        .i_nil_value  (r_in_nil),
        .i_has_byte   (r_in_hb),
        .i_data_byte  (r_in_byte),
        .i_last_byte  (r_in_last),
        .o_ctl        (n_ctl),
        .o_mag        (n_mag),
        .o_verdict    (verdict)
    );

    assign advance       = r_in_valid && (!verdict.done || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_form, r_out_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctl       <= SCAN_CLEAR;
            r_mag       <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_ctl <= n_ctl;
                r_mag <= n_mag;
            end
            if (advance && verdict.done) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_type <= s_axis_tuser[2:0];
            r_in_nil  <= s_axis_tuser[3];
            r_in_hb   <= s_axis_tuser[4];
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (advance && verdict.done) begin
            r_out_status <= verdict.status;
            r_out_form   <= verdict.form;
        end
    end

endmodule
